// ===== hdl/aqm_pkg.sv =====
// Shared constants, types and arctangent table for the arrow quad measure block.
package aqm_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int NPTS = 4;
  localparam int CORDIC_STEPS = 30;
  localparam int ZW = 33;           // angle accumulator, pi/2^31 units plus sign
  localparam int CW = 45;           // cordic x/y width (below 2^41 scale, gain and sign)

  // Command word from the sequencer to the shared unit.
  typedef enum logic [1:0] {
    OP_SQRT  = 2'd0,
    OP_ATAN  = 2'd1
  } aqm_op_t;

  typedef struct packed {
    logic    start;
    aqm_op_t op;
  } aqm_cmd_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    begin
      v = '0;
      unique case (idx)
        5'd0:  v = 33'h020000000;
        5'd1:  v = 33'h012E4051D;
        5'd2:  v = 33'h009FB385B;
        5'd3:  v = 33'h0051111D4;
        5'd4:  v = 33'h0028B0D43;
        5'd5:  v = 33'h00145D7E1;
        5'd6:  v = 33'h000A2F61E;
        5'd7:  v = 33'h000517C55;
        5'd8:  v = 33'h00028BE53;
        5'd9:  v = 33'h000145F2E;
        5'd10: v = 33'h0000A2F98;
        5'd11: v = 33'h0000517CC;
        5'd12: v = 33'h000028BE6;
        5'd13: v = 33'h0000145F3;
        5'd14: v = 33'h00000A2F9;
        5'd15: v = 33'h00000517C;
        5'd16: v = 33'h0000028BE;
        5'd17: v = 33'h00000145F;
        5'd18: v = 33'h000000A2F;
        5'd19: v = 33'h000000517;
        5'd20: v = 33'h00000028B;
        5'd21: v = 33'h000000145;
        5'd22: v = 33'h0000000A2;
        5'd23: v = 33'h000000051;
        5'd24: v = 33'h000000028;
        5'd25: v = 33'h000000014;
        5'd26: v = 33'h00000000A;
        5'd27: v = 33'h000000005;
        5'd28: v = 33'h000000002;
        5'd29: v = 33'h000000001;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hdl/aqm_unit.sv =====
// Shared iterative unit: bit-serial square root or CORDIC vectoring, one step a cycle.
module aqm_unit #(
  parameter int COORD_WIDTH = aqm_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = aqm_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aqm_pkg::aqm_cmd_t            cmd,
  // sqrt operand: dx^2+dy^2; atan operand: vector components
  input  logic [2*COORD_WIDTH+2:0]     rad,
  input  logic signed [COORD_WIDTH+2:0] vx,
  input  logic signed [COORD_WIDTH+2:0] vy,
  output logic                         done,
  output logic [COORD_WIDTH+1:0]       root,
  output logic signed [ANGLE_WIDTH-1:0] angle
);
  localparam int RW = COORD_WIDTH + 2;        // root width
  localparam int NW = 2 * COORD_WIDTH + 3;    // radicand width
  localparam int QW = 2 * RW;                 // radicand padded to whole bit pairs
  localparam int CW = aqm_pkg::CW;
  localparam int ZW = aqm_pkg::ZW;
  localparam int SQ_STEPS = RW;
  localparam int CNTW = 6;

  typedef enum logic [1:0] {S_IDLE, S_SQRT, S_NORM, S_ROT} st_t;

  st_t st_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0] rem_r;
  logic [QW-1:0] num_r;
  logic [RW-1:0] root_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic done_r;
  logic signed [ANGLE_WIDTH-1:0] angle_r;

  // sqrt step: shift two radicand bits into the remainder, try root*4+1
  logic [NW+1:0] rem_sh, trial;
  logic [RW-1:0] root_sh;
  always_comb begin
    rem_sh  = {rem_r, num_r[QW-1 -: 2]};
    trial   = {{(NW+2-RW-2){1'b0}}, root_r, 2'b01};
    root_sh = {root_r[RW-2:0], 1'b0};
  end

  // cordic step
  logic signed [CW-1:0] xs, ys;
  logic [4:0] idx;
  logic signed [ZW-1:0] za;
  logic signed [ZW-1:0] zr;
  always_comb begin
    idx = cnt_r[4:0];
    xs  = x_r >>> idx;
    ys  = y_r >>> idx;
    za  = aqm_pkg::atan_entry(idx);
    zr  = z_r + (ZW'(1) <<< (31 - ANGLE_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd.start) begin
            cnt_r <= '0;
            if (cmd.op == aqm_pkg::OP_SQRT) begin
              num_r  <= QW'(rad);
              rem_r  <= '0;
              root_r <= '0;
              st_r   <= S_SQRT;
            end else begin
              x_r <= CW'(vx);
              y_r <= CW'(vy);
              z_r <= '0;
              if (vx == '0 && vy == '0) begin
                angle_r <= '0;
                done_r  <= 1'b1;
              end else begin
                st_r <= S_NORM;
              end
            end
          end
        end
        S_SQRT: begin
          num_r <= {num_r[QW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r  <= NW'(rem_sh - trial);
            root_r <= root_sh | RW'(1);
          end else begin
            rem_r  <= NW'(rem_sh);
            root_r <= root_sh;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(SQ_STEPS - 1)) begin
            done_r <= 1'b1;
            st_r   <= S_IDLE;
          end
        end
        S_NORM: begin
          // scale left until the larger magnitude reaches 2^40, then fold
          if (!((x_r[CW-1] ? -x_r : x_r) >= (CW'(1) <<< 40) ||
                (y_r[CW-1] ? -y_r : y_r) >= (CW'(1) <<< 40))) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            if (x_r < 0) begin
              if (y_r >= 0) begin
                x_r <= y_r; y_r <= -x_r; z_r <= ZW'(1) <<< 30;
              end else begin
                x_r <= -y_r; y_r <= x_r; z_r <= -(ZW'(1) <<< 30);
              end
            end
            cnt_r <= '0;
            st_r  <= S_ROT;
          end
        end
        S_ROT: begin
          if (cnt_r == CNTW'(aqm_pkg::CORDIC_STEPS)) begin
            angle_r <= ANGLE_WIDTH'(zr >>> (32 - ANGLE_WIDTH));
            done_r  <= 1'b1;
            st_r    <= S_IDLE;
          end else begin
            if (y_r > 0) begin
              x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + za;
            end else begin
              x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - za;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign root  = root_r;
  assign angle = angle_r;

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> st_r == S_IDLE) else $error("start while unit busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> st_r == S_IDLE) else $error("done while unit busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done longer than one cycle");
endmodule

// ===== hdl/arrow_quad_measure.sv =====
// Top level: corner store, ordering, sequencer over the shared unit and output register.
//
// channel | dir | fields (low bit up)
// in_     | in  | tdata: point_x, point_y, point_z
// out_    | out | tdata: result_x, result_y, result_z, length, width, heading;
//         |     | tuser: is_summary; tlast: last
//
// A corner word is stored when it is accepted; the first three words of a run give no output.
// The fourth word starts the measure: ordering and sums, four square roots of
// COORD_WIDTH+2 steps each and one CORDIC run (scale and fold, then rotate) on the one
// shared unit, each job issued from S_CALC and handed back in S_WAIT; then five output words.
// in_tready is low from the fourth word until the summary word is taken.
// Reset clears the point count and sequencer; stored corners need none.
// A stalled out_tready holds the current output word.
module arrow_quad_measure #(
  parameter int COORD_WIDTH = aqm_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = aqm_pkg::ANGLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,   // point_x, point_y, point_z
  output logic out_tvalid,
  input  logic out_tready,
  // result_x, result_y, result_z, length, width, heading
  output logic [((5*COORD_WIDTH+2+ANGLE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic out_tuser,    // is_summary
  output logic out_tlast     // last
);
  localparam int W   = COORD_WIDTH;
  localparam int LW  = W + 1;
  localparam int OW  = ((5*W+2+ANGLE_WIDTH+7)/8)*8;
  localparam int RW  = W + 2;
  localparam int VW  = W + 3;
  localparam int NW  = 2*W + 3;

  typedef enum logic [2:0] {S_COLLECT, S_ORDER, S_SUMS, S_CALC, S_WAIT, S_EMIT} st_t;

  st_t st_r;
  logic [1:0] cnt_r;
  logic signed [W-1:0] sx_r [aqm_pkg::NPTS];
  logic signed [W-1:0] sy_r [aqm_pkg::NPTS];
  logic signed [W-1:0] sz_r [aqm_pkg::NPTS];
  logic [1:0] ord_r [aqm_pkg::NPTS];
  logic signed [W+1:0] cx_r, cy_r, cz_r;
  logic signed [VW-1:0] hx_r, hy_r;
  logic [2:0] job_r;       // 0..3 distances, 4 heading
  logic [RW:0] lsum_r, wsum_r;
  logic signed [ANGLE_WIDTH-1:0] hd_r;
  logic [2:0] emit_r;
  logic ovalid_r;
  logic [OW-1:0] odata_r;
  logic olast_r;
  logic issued_r;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (st_r == S_COLLECT);

  // stable descending rank by x: count points that must go ahead of each
  logic [1:0] rank [aqm_pkg::NPTS];
  logic [1:0] r2i  [aqm_pkg::NPTS];
  always_comb begin
    for (int i = 0; i < aqm_pkg::NPTS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < aqm_pkg::NPTS; j++)
        if ((j < i && sx_r[j] >= sx_r[i]) || (j > i && sx_r[j] > sx_r[i]))
          rank[i] = rank[i] + 2'd1;
    end
    for (int k = 0; k < aqm_pkg::NPTS; k++) begin
      r2i[k] = '0;
      for (int i = 0; i < aqm_pkg::NPTS; i++)
        if (rank[i] == 2'(k)) r2i[k] = 2'(i);
    end
  end

  // ordered corner taps
  logic signed [W-1:0] px [aqm_pkg::NPTS];
  logic signed [W-1:0] py [aqm_pkg::NPTS];
  logic signed [W-1:0] pz [aqm_pkg::NPTS];
  always_comb
    for (int n = 0; n < aqm_pkg::NPTS; n++) begin
      px[n] = sx_r[ord_r[n]];
      py[n] = sy_r[ord_r[n]];
      pz[n] = sz_r[ord_r[n]];
    end

  // operand select for the current distance job
  logic [1:0] ea, eb;
  logic signed [W:0] ddx, ddy;
  logic [W:0] adx, ady;
  logic [NW-1:0] radicand;
  always_comb begin
    unique case (job_r[1:0])
      2'd0: begin ea = 2'd0; eb = 2'd1; end
      2'd1: begin ea = 2'd2; eb = 2'd3; end
      2'd2: begin ea = 2'd0; eb = 2'd3; end
      default: begin ea = 2'd1; eb = 2'd2; end
    endcase
    ddx = (W+1)'(px[ea]) - (W+1)'(px[eb]);
    ddy = (W+1)'(py[ea]) - (W+1)'(py[eb]);
    adx = ddx[W] ? (W+1)'(-ddx) : ddx;
    ady = ddy[W] ? (W+1)'(-ddy) : ddy;
    radicand = NW'(adx * adx) + NW'(ady * ady);
  end

  aqm_pkg::aqm_cmd_t cmd;
  logic u_done;
  logic [RW-1:0] u_root;
  logic signed [ANGLE_WIDTH-1:0] u_angle;
  always_comb begin
    cmd.start = (st_r == S_CALC);
    cmd.op    = (job_r == 3'd4) ? aqm_pkg::OP_ATAN : aqm_pkg::OP_SQRT;
  end

  aqm_unit #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_unit (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .rad(radicand), .vx(hx_r), .vy(hy_r),
    .done(u_done), .root(u_root), .angle(u_angle)
  );

  // output word for the current emit slot
  logic [OW-1:0] word;
  logic signed [W-1:0] cxo, cyo, czo;
  always_comb begin
    cxo = W'(cx_r >>> 2);
    cyo = W'(cy_r >>> 2);
    czo = W'(cz_r >>> 2);
    if (emit_r == 3'd4)
      word = OW'({hd_r, LW'(wsum_r >> 1), LW'(lsum_r >> 1), czo, cyo, cxo});
    else
      word = OW'({pz[emit_r[1:0]], py[emit_r[1:0]], px[emit_r[1:0]]});
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sx_r[cnt_r] <= in_tdata[W-1:0];
      sy_r[cnt_r] <= in_tdata[2*W-1:W];
      sz_r[cnt_r] <= in_tdata[3*W-1:2*W];
    end
    if (!rst_n) begin
      st_r     <= S_COLLECT;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      issued_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_COLLECT: begin
          if (in_acc) begin
            cnt_r <= cnt_r + 2'd1;
            if (cnt_r == 2'd3) st_r <= S_ORDER;
          end
        end
        S_ORDER: begin
          // pair ranks 0,1 and 2,3 by y; on equal y the later rank leads
          if (sy_r[r2i[0]] > sy_r[r2i[1]]) begin
            ord_r[0] <= r2i[0]; ord_r[3] <= r2i[1];
          end else begin
            ord_r[0] <= r2i[1]; ord_r[3] <= r2i[0];
          end
          if (sy_r[r2i[2]] > sy_r[r2i[3]]) begin
            ord_r[1] <= r2i[2]; ord_r[2] <= r2i[3];
          end else begin
            ord_r[1] <= r2i[3]; ord_r[2] <= r2i[2];
          end
          st_r <= S_SUMS;
        end
        S_SUMS: begin
          cx_r <= (W+2)'(px[0]) + (W+2)'(px[1]) + (W+2)'(px[2]) + (W+2)'(px[3]);
          cy_r <= (W+2)'(py[0]) + (W+2)'(py[1]) + (W+2)'(py[2]) + (W+2)'(py[3]);
          cz_r <= (W+2)'(pz[0]) + (W+2)'(pz[1]) + (W+2)'(pz[2]) + (W+2)'(pz[3]);
          hx_r <= VW'(px[0]) + VW'(px[3]) - VW'(px[1]) - VW'(px[2]);
          hy_r <= VW'(py[0]) + VW'(py[3]) - VW'(py[1]) - VW'(py[2]);
          lsum_r <= '0;
          wsum_r <= '0;
          job_r  <= '0;
          st_r   <= S_CALC;
        end
        S_CALC: st_r <= S_WAIT;
        S_WAIT: begin
          if (u_done) begin
            if (job_r == 3'd4) begin
              hd_r   <= u_angle;
              emit_r <= '0;
              st_r   <= S_EMIT;
            end else begin
              if (job_r[1]) wsum_r <= wsum_r + (RW+1)'(u_root);
              else          lsum_r <= lsum_r + (RW+1)'(u_root);
              job_r <= job_r + 3'd1;
              st_r  <= S_CALC;
            end
          end
        end
        S_EMIT: begin
          // load the output register when empty or being drained
          if (!ovalid_r || out_acc) begin
            if (issued_r && olast_r) begin
              ovalid_r <= 1'b0;
              issued_r <= 1'b0;
              st_r     <= S_COLLECT;
            end else begin
              ovalid_r <= 1'b1;
              odata_r  <= word;
              olast_r  <= (emit_r == 3'd4);
              issued_r <= 1'b1;
              emit_r   <= emit_r + 3'd1;
            end
          end
        end
        default: st_r <= S_COLLECT;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = olast_r;
  assign out_tlast  = olast_r;

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while output pending");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_COLLECT) |-> cnt_r == 2'd0) else $error("point count not wrapped");
  a_last_user: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == out_tlast) else $error("summary flags differ");
endmodule
